@@ src/feature_delta_varint_decoder_defines.svh @@
// Assertion macros for the feature delta varint decoder.
// Used by the top level only; no other dependencies.
`ifndef FEATURE_DELTA_VARINT_DECODER_DEFINES_SVH
`define FEATURE_DELTA_VARINT_DECODER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define FDV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fdv assertion failed");
// Next-cycle implication, checked out of reset.
`define FDV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fdv assertion failed");
`else
`define FDV_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FDV_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ src/fdv_pkg.sv @@
// Shared types, constants and helpers for the feature delta varint decoder.
// No dependencies.
`default_nettype none

package fdv_pkg;

  localparam logic [31:0] POS_ONE_BITS = 32'h3F80_0000;
  localparam logic [31:0] NEG_ONE_BITS = 32'hBF80_0000;
  localparam logic [3:0]  MAX_VARINT_BYTES = 4'd10;
  localparam logic [1:0]  LAST_VALUE_BYTE = 2'd3;

  localparam logic [1:0] ERR_NONE        = 2'd0;
  localparam logic [1:0] ERR_OVERLONG    = 2'd1;
  localparam logic [1:0] ERR_MID_FEATURE = 2'd2;

  typedef enum logic [1:0] {
    PH_VARINT = 2'b01,
    PH_VALUE  = 2'b10
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_start;
    logic       block_end;
  } in_t;

  typedef struct packed {
    logic [63:0] feat_idx;
    logic [31:0] value_bits;
    logic        out_of_order;
    logic        ends_block;
    logic [1:0]  error_code;
  } out_t;

  // Decoder status seen by the top level.
  typedef struct packed {
    logic       in_value;
    logic [3:0] varint_cnt;
  } status_t;

  // Bit position of the next 7-bit group: 7 * (count mod 10).
  function automatic logic [5:0] varint_shift(input logic [3:0] cnt);
    logic [5:0] sh;
    case (cnt)
      4'd0:    sh = 6'd0;
      4'd1:    sh = 6'd7;
      4'd2:    sh = 6'd14;
      4'd3:    sh = 6'd21;
      4'd4:    sh = 6'd28;
      4'd5:    sh = 6'd35;
      4'd6:    sh = 6'd42;
      4'd7:    sh = 6'd49;
      4'd8:    sh = 6'd56;
      4'd9:    sh = 6'd63;
      4'd10:   sh = 6'd0;
      4'd11:   sh = 6'd7;
      4'd12:   sh = 6'd14;
      4'd13:   sh = 6'd21;
      4'd14:   sh = 6'd28;
      4'd15:   sh = 6'd35;
      default: sh = 6'd0;
    endcase
    return sh;
  endfunction

endpackage

`default_nettype wire

@@ src/feature_delta_varint_decoder.sv @@
// Decodes a byte stream of zigzag delta varint feature indices, one byte per cycle
// while the result side is not stalled. Throughput is one byte per cycle under the
// same condition. The byte that completes a feature passes the input register, then
// the result register, before out_valid rises. The loop that sets the rate is the
// update of the running index and varint state, which holds one 64-bit add. in_ready
// follows out_ready combinationally through the one-entry input stage. Bytes that
// complete no feature and raise no error produce no transaction on the result side.
// Depends on fdv_pkg, fdv_in_stage, fdv_core, fdv_out_stage and the assertion macro header.
`default_nettype none

`include "feature_delta_varint_decoder_defines.svh"

module feature_delta_varint_decoder (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire fdv_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output fdv_pkg::out_t      out_data
);
  import fdv_pkg::*;

  logic    stg_valid;
  in_t     stg_data;
  logic    can_take;
  logic    adv;
  logic    res_valid;
  out_t    res;
  status_t status;

  assign adv = stg_valid && can_take;

  fdv_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .adv       (adv),
    .stg_valid (stg_valid),
    .stg_data  (stg_data)
  );

  fdv_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .byte_in   (stg_data),
    .res_valid (res_valid),
    .res       (res),
    .status    (status)
  );

  fdv_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (adv && res_valid),
    .res       (res),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `FDV_ASSERT_IMP(a_err_zero_payload, clk, rst_n, out_valid && (out_data.error_code != ERR_NONE), (out_data.feat_idx == 64'd0) && (out_data.value_bits == 32'd0) && !out_data.out_of_order)
  `FDV_ASSERT_IMP(a_mid_feature_ends, clk, rst_n, out_valid && (out_data.error_code == ERR_MID_FEATURE), out_data.ends_block)
  `FDV_ASSERT_IMP(a_value_phase_cnt, clk, rst_n, status.in_value, status.varint_cnt == 4'd0)
  `FDV_ASSERT_NXT(a_stall_holds_state, clk, rst_n, stg_valid && !can_take, $stable(status))

endmodule

`default_nettype wire

@@ src/fdv_in_stage.sv @@
// Input register stage of the feature delta varint decoder.
// Depends on fdv_pkg.
`default_nettype none

module fdv_in_stage (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire fdv_pkg::in_t in_data,
  input  wire logic         adv,
  output logic              stg_valid,
  output fdv_pkg::in_t      stg_data
);
  import fdv_pkg::*;

  logic stg_v_r, stg_v_nxt;
  in_t  stg_d_r;
  logic load;

  assign in_ready  = !stg_v_r || adv;
  assign load      = in_valid && in_ready;
  assign stg_v_nxt = load ? 1'b1 : (adv ? 1'b0 : stg_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stg_d_r <= in_data;
    end
  end

  assign stg_valid = stg_v_r;
  assign stg_data  = stg_d_r;

endmodule

`default_nettype wire

@@ src/fdv_core.sv @@
// Decode state and per-byte decode logic of the feature delta varint decoder.
// Depends on fdv_pkg.
`default_nettype none

module fdv_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         adv,
  input  wire fdv_pkg::in_t byte_in,
  output logic              res_valid,
  output fdv_pkg::out_t     res,
  output fdv_pkg::status_t  status
);
  import fdv_pkg::*;

  logic [63:0] prev_r, prev_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  phase_t      phase_r, phase_nxt;
  logic [1:0]  vcnt_r, vcnt_nxt;
  logic [31:0] vasm_r, vasm_nxt;

  // State after an optional block start
  logic [63:0] prev0, acc0;
  logic [3:0]  cnt0;
  phase_t      phase0;
  logic [1:0]  vcnt0;
  logic [31:0] vasm0;

  logic [7:0]  b;
  logic        blk_end;
  logic [63:0] acc1, feat_acc, diff, delta, idx;
  logic [3:0]  cnt1;
  logic [31:0] vasm1;
  logic        emit_feat, emit_err;
  logic [31:0] feat_bits;
  logic [1:0]  err_code;
  logic        err_end;

  assign b       = byte_in.data_byte;
  assign blk_end = byte_in.block_end;

  always_comb begin
    if (byte_in.block_start) begin
      prev0  = '0;
      acc0   = '0;
      cnt0   = '0;
      phase0 = PH_VARINT;
      vcnt0  = '0;
      vasm0  = '0;
    end else begin
      prev0  = prev_r;
      acc0   = acc_r;
      cnt0   = cnt_r;
      phase0 = phase_r;
      vcnt0  = vcnt_r;
      vasm0  = vasm_r;
    end
  end

  assign acc1  = acc0 | ({57'd0, b[6:0]} << varint_shift(cnt0));
  assign cnt1  = cnt0 + 4'd1;
  assign vasm1 = vasm0 | ({24'd0, b} << {vcnt0, 3'b000});

  // Zigzag delta from the gathered word, then the wrapping add
  assign diff  = {2'b00, feat_acc[63:2]};
  assign delta = {1'b0, diff[63:1]} ^ {64{diff[0]}};
  assign idx   = prev0 + delta;

  always_comb begin
    acc_nxt    = acc0;
    cnt_nxt    = cnt0;
    phase_nxt  = phase0;
    vcnt_nxt   = vcnt0;
    vasm_nxt   = vasm0;
    prev_nxt   = prev0;
    feat_acc   = acc0;
    feat_bits  = POS_ONE_BITS;
    emit_feat  = 1'b0;
    emit_err   = 1'b0;
    err_code   = ERR_NONE;
    err_end    = 1'b1;
    case (phase0)
      PH_VARINT: begin
        feat_acc = acc1;
        acc_nxt  = acc1;
        if (b[7]) begin
          cnt_nxt = cnt1;
          if (cnt1 >= MAX_VARINT_BYTES) begin
            emit_err = 1'b1;
            err_code = ERR_OVERLONG;
            err_end  = blk_end;
          end else if (blk_end) begin
            emit_err = 1'b1;
            err_code = ERR_MID_FEATURE;
          end
        end else begin
          cnt_nxt = '0;
          if (acc1[0]) begin
            emit_feat = 1'b1;
            feat_bits = NEG_ONE_BITS;
          end else if (acc1[1]) begin
            phase_nxt = PH_VALUE;
            vcnt_nxt  = '0;
            vasm_nxt  = '0;
            if (blk_end) begin
              emit_err = 1'b1;
              err_code = ERR_MID_FEATURE;
            end
          end else begin
            emit_feat = 1'b1;
          end
        end
      end
      PH_VALUE: begin
        vasm_nxt = vasm1;
        if (vcnt0 == LAST_VALUE_BYTE) begin
          emit_feat = 1'b1;
          feat_bits = vasm1;
        end else begin
          vcnt_nxt = vcnt0 + 2'd1;
          if (blk_end) begin
            emit_err = 1'b1;
            err_code = ERR_MID_FEATURE;
          end
        end
      end
      default: begin
        phase_nxt = PH_VARINT;
      end
    endcase

    // Any result ends the partial feature
    if (emit_feat || emit_err) begin
      acc_nxt   = '0;
      cnt_nxt   = '0;
      phase_nxt = PH_VARINT;
      vcnt_nxt  = '0;
      vasm_nxt  = '0;
    end
    if (emit_feat) begin
      prev_nxt = idx;
    end
  end

  always_comb begin
    res_valid = emit_feat || emit_err;
    if (emit_feat) begin
      res.feat_idx     = idx;
      res.value_bits   = feat_bits;
      res.out_of_order = delta[63];
      res.ends_block   = blk_end;
      res.error_code   = ERR_NONE;
    end else begin
      res.feat_idx     = '0;
      res.value_bits   = '0;
      res.out_of_order = 1'b0;
      res.ends_block   = err_end;
      res.error_code   = err_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      acc_r   <= '0;
      cnt_r   <= '0;
      phase_r <= PH_VARINT;
      vcnt_r  <= '0;
      vasm_r  <= '0;
    end else if (adv) begin
      prev_r  <= prev_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
      vcnt_r  <= vcnt_nxt;
      vasm_r  <= vasm_nxt;
    end
  end

  assign status.in_value   = (phase_r == PH_VALUE);
  assign status.varint_cnt = cnt_r;

endmodule

`default_nettype wire

@@ src/fdv_out_stage.sv @@
// Result register of the feature delta varint decoder.
// Depends on fdv_pkg.
`default_nettype none

module fdv_out_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          ld,
  input  wire fdv_pkg::out_t res,
  output logic               can_take,
  output logic               out_valid,
  input  wire logic          out_ready,
  output fdv_pkg::out_t      out_data
);
  import fdv_pkg::*;

  logic out_v_r, out_v_nxt;
  out_t out_d_r;

  assign can_take  = !out_v_r || out_ready;
  assign out_v_nxt = ld ? 1'b1 : (out_ready ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_d_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule

`default_nettype wire
